@@ sv/mhpq_pkg.sv @@
// Shared types and constants for the max-heap priority queue.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package mhpq_pkg;

   // Store size and the widths that follow from it.
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;

   // Request operation codes.
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // Response status codes.
   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_START_INS,
      OP_UP_READ,
      OP_UP_MOVE,
      OP_PLACE,
      OP_DN_START,
      OP_DN_LOAD,
      OP_DN_READ,
      OP_DN_MOVE,
      OP_RESP
   } dp_op_type;

   typedef struct packed {
      logic                    func;
      logic signed [KEY_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [KEY_W-1:0] top_value;
      logic [CNT_W-1:0]        count;
   } rsp_type;

   typedef struct packed {
      dp_op_type  op;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic at_root;
      logic no_left;
      logic up_swap;
      logic dn_swap;
   } dp_status_type;

endpackage

@@ sv/max_heap_priority_queue_unit.sv @@
// Top level of the max-heap priority queue.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_dpath.
`timescale 1ns / 1ps

// The unit holds up to 64 signed 32-bit keys as a binary max-heap and takes
// one request at a time: insert a key or remove the maximum. Every request
// gives exactly one response with a status (done, full, or empty), the
// largest key left (zero when empty) and the new count. An insert moves the
// key up toward the root; a remove moves the last key to the root and sifts
// it down. Each tree level costs one registered read of the key store and
// one compare and write-back step. A new request is accepted as soon as the
// previous one has been loaded into the response register, even while that
// response waits.

module max_heap_priority_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mhpq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mhpq_pkg::rsp_type rsp_payload
);

   mhpq_pkg::dp_cmd_type    cmd;
   mhpq_pkg::dp_status_type dp_status;

   // Sequencing of each request.
   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_payload.func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // Key store and sift datapath.
   mhpq_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .dp_status   (dp_status),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ sv/mhpq_dpath.sv @@
// Datapath of the heap: key store, count, sift position, carried key and
// response register. Depends on mhpq_pkg; driven by mhpq_ctrl commands.
`timescale 1ns / 1ps

module mhpq_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  mhpq_pkg::dp_cmd_type   cmd,
   input  mhpq_pkg::req_type      req_payload,
   output mhpq_pkg::dp_status_type dp_status,
   output mhpq_pkg::rsp_type      rsp_payload
);

   localparam int IDX_W = mhpq_pkg::IDX_W;
   localparam int CNT_W = mhpq_pkg::CNT_W;
   localparam int KEY_W = mhpq_pkg::KEY_W;

   // Key store, positions 1..CAPACITY kept at addresses 0..CAPACITY-1.
   logic signed [KEY_W-1:0] mem [mhpq_pkg::CAPACITY];

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic signed [KEY_W-1:0] val_ff, val_in;
   logic signed [KEY_W-1:0] top_ff, top_in;
   logic signed [KEY_W-1:0] rd0_ff, rd1_ff;
   mhpq_pkg::rsp_type       rsp_ff, rsp_in;

   logic [CNT_W-1:0]        parent;
   logic [CNT_W:0]          left, right, count_x;
   logic [IDX_W-1:0]        rd0_addr, rd1_addr, wr_addr;
   logic                    wr_en;
   logic signed [KEY_W-1:0] wr_data;
   logic                    take_l, take_r, right_in;
   logic signed [KEY_W-1:0] best_key, move_key;
   logic [CNT_W-1:0]        move_pos;

   // Tree arithmetic around the current position.
   always_comb begin
      parent  = pos_ff >> 1;
      left    = {pos_ff, 1'b0};
      right   = left + 1'b1;
      count_x = {1'b0, count_ff};
   end

   // Sift-down choice: the larger child wins only when strictly larger,
   // and the left child wins a tie.
   always_comb begin
      right_in = right <= count_x;
      take_l   = val_ff < rd0_ff;
      best_key = take_l ? rd0_ff : val_ff;
      take_r   = right_in && (best_key < rd1_ff);
      move_key = take_r ? rd1_ff : rd0_ff;
      move_pos = take_r ? CNT_W'(right) : CNT_W'(left);
   end

   // Status back to the controller.
   always_comb begin
      dp_status.count_zero = count_ff == '0;
      dp_status.count_full = count_ff >= CNT_W'(mhpq_pkg::CAPACITY);
      dp_status.at_root    = pos_ff == CNT_W'(1);
      dp_status.no_left    = left > count_x;
      dp_status.up_swap    = rd0_ff < val_ff;
      dp_status.dn_swap    = take_l || take_r;
   end

   // Memory port addressing and write data.
   always_comb begin
      case (cmd.op)
         mhpq_pkg::OP_UP_READ:  rd0_addr = IDX_W'(parent - 1'b1);
         mhpq_pkg::OP_DN_START: rd0_addr = IDX_W'(count_ff - 1'b1);
         default:               rd0_addr = IDX_W'(left - 1'b1);
      endcase
      rd1_addr = IDX_W'(left);
      wr_addr  = IDX_W'(pos_ff - 1'b1);
      wr_en    = 1'b0;
      wr_data  = val_ff;
      case (cmd.op)
         mhpq_pkg::OP_PLACE: begin
            wr_en   = 1'b1;
            wr_data = val_ff;
         end
         mhpq_pkg::OP_UP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rd0_ff;
         end
         mhpq_pkg::OP_DN_MOVE: begin
            wr_en   = 1'b1;
            wr_data = move_key;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // Next values of the datapath registers.
   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      top_in   = top_ff;
      rsp_in   = rsp_ff;
      if (wr_en && (pos_ff == CNT_W'(1))) begin
         top_in = wr_data;
      end
      case (cmd.op)
         mhpq_pkg::OP_START_INS: begin
            count_in = count_ff + 1'b1;
            pos_in   = count_ff + 1'b1;
            val_in   = req_payload.value;
         end
         mhpq_pkg::OP_UP_MOVE: pos_in = parent;
         mhpq_pkg::OP_DN_START: begin
            count_in = count_ff - 1'b1;
            pos_in   = CNT_W'(1);
         end
         mhpq_pkg::OP_DN_LOAD: val_in = rd0_ff;
         mhpq_pkg::OP_DN_MOVE: pos_in = move_pos;
         mhpq_pkg::OP_RESP: begin
            rsp_in.status    = cmd.status;
            rsp_in.top_value = (count_ff == '0) ? '0 : top_ff;
            rsp_in.count     = count_ff;
         end
         default: count_in = count_ff;
      endcase
   end

   // Key store with one write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_ff <= mem[rd0_addr];
      rd1_ff <= mem[rd1_addr];
   end

   // Count is control state; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff <= pos_in;
      val_ff <= val_in;
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(mhpq_pkg::CAPACITY))
      else $error("entry count above capacity");

   // A key is only placed at an occupied position, or at the root of a heap
   // that a remove has just emptied.
   a_place_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == mhpq_pkg::OP_PLACE |-> pos_ff >= CNT_W'(1)
         && (pos_ff <= count_ff || pos_ff == CNT_W'(1)))
      else $error("key placed outside occupied range");

   // A sift-down move always goes deeper into the tree.
   a_down_deeper: assert property (@(posedge clock) disable iff (reset)
      cmd.op == mhpq_pkg::OP_DN_MOVE |=> pos_ff > $past(pos_ff))
      else $error("sift-down did not descend");

endmodule

@@ sv/mhpq_ctrl.sv @@
// Controller state machine of the heap: request intake, sift sequencing
// and response handshake. Depends on mhpq_pkg; drives mhpq_dpath.
`timescale 1ns / 1ps

module mhpq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_func,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  mhpq_pkg::dp_status_type dp_status,
   output mhpq_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_TEST,
      ST_UP_CMP,
      ST_DN_LOAD,
      ST_DN_TEST,
      ST_DN_CMP,
      ST_RESP
   } state_type;

   state_type            state_ff, state_in;
   mhpq_pkg::status_type status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_take;

   assign req_stall = state_ff != ST_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state, datapath command and response valid.
   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = mhpq_pkg::OP_NONE;
      cmd.status   = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               status_in = mhpq_pkg::STAT_DONE;
               if (req_func == mhpq_pkg::FUNC_INSERT) begin
                  if (dp_status.count_full) begin
                     status_in = mhpq_pkg::STAT_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     cmd.op   = mhpq_pkg::OP_START_INS;
                     state_in = ST_UP_TEST;
                  end
               end else begin
                  if (dp_status.count_zero) begin
                     status_in = mhpq_pkg::STAT_EMPTY;
                     state_in  = ST_RESP;
                  end else begin
                     cmd.op   = mhpq_pkg::OP_DN_START;
                     state_in = ST_DN_LOAD;
                  end
               end
            end
         end
         ST_UP_TEST: begin
            if (dp_status.at_root) begin
               cmd.op   = mhpq_pkg::OP_PLACE;
               state_in = ST_RESP;
            end else begin
               cmd.op   = mhpq_pkg::OP_UP_READ;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (dp_status.up_swap) begin
               cmd.op   = mhpq_pkg::OP_UP_MOVE;
               state_in = ST_UP_TEST;
            end else begin
               cmd.op   = mhpq_pkg::OP_PLACE;
               state_in = ST_RESP;
            end
         end
         ST_DN_LOAD: begin
            cmd.op   = mhpq_pkg::OP_DN_LOAD;
            state_in = ST_DN_TEST;
         end
         ST_DN_TEST: begin
            if (dp_status.no_left) begin
               cmd.op   = mhpq_pkg::OP_PLACE;
               state_in = ST_RESP;
            end else begin
               cmd.op   = mhpq_pkg::OP_DN_READ;
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (dp_status.dn_swap) begin
               cmd.op   = mhpq_pkg::OP_DN_MOVE;
               state_in = ST_DN_TEST;
            end else begin
               cmd.op   = mhpq_pkg::OP_PLACE;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // Load the response register once it is free or being taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = mhpq_pkg::OP_RESP;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         status_ff    <= mhpq_pkg::STAT_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted request always starts work.
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("request accepted without leaving idle");

   // An insert into a full heap goes straight to the response with full status.
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      req_take && req_func == mhpq_pkg::FUNC_INSERT && dp_status.count_full
      |=> state_ff == ST_RESP && status_ff == mhpq_pkg::STAT_FULL)
      else $error("insert into full heap not dropped");

   // Leaving the response state always presents a response.
   a_resp_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP && state_in == ST_IDLE |=> rsp_valid_ff)
      else $error("response lost");

endmodule

@@ tb/max_heap_priority_queue_unit_tb.sv @@
// Self-checking testbench for the max-heap priority queue unit.
// Depends on mhpq_pkg and max_heap_priority_queue_unit, with its mhpq_ctrl and mhpq_dpath.
`timescale 1ns / 1ps

module max_heap_priority_queue_unit_tb;

   localparam int CYCLE_LIMIT = 500000;
   localparam int IDLE_PCT    = 30;
   localparam int DRAIN_WAIT  = 40;
   localparam int KEY_W       = mhpq_pkg::KEY_W;
   localparam int CNT_W       = mhpq_pkg::CNT_W;
   localparam int CAPACITY    = mhpq_pkg::CAPACITY;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   mhpq_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   mhpq_pkg::rsp_type rsp_payload;

   // Shadow copy of the heap, updated as each request is accepted.
   logic signed [KEY_W-1:0] shadow_keys [1:CAPACITY];
   int                      shadow_count;
   mhpq_pkg::rsp_type       pending_heap_rsps [$];

   int  mismatch_count;
   int  hold_cycles_left;
   bit  req_gaps_on;
   bit  rsp_gaps_on;

   max_heap_priority_queue_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // 10 ns clock; it starts low so the first rising edge already sees reset.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Apply one request to the shadow heap and return the response it should give.
   function automatic mhpq_pkg::rsp_type next_heap_response(mhpq_pkg::req_type rq);
      mhpq_pkg::rsp_type       r;
      int                      pos;
      int                      child;
      int                      larger;
      logic signed [KEY_W-1:0] tmp;
      r.status = mhpq_pkg::STAT_DONE;
      if (rq.func == mhpq_pkg::FUNC_INSERT) begin
         if (shadow_count >= CAPACITY) begin
            r.status = mhpq_pkg::STAT_FULL;
         end else begin
            shadow_count++;
            shadow_keys[shadow_count] = rq.value;
            pos = shadow_count;
            // Climb while the parent is strictly smaller.
            while (pos > 1 && shadow_keys[pos / 2] < shadow_keys[pos]) begin
               tmp = shadow_keys[pos / 2];
               shadow_keys[pos / 2] = shadow_keys[pos];
               shadow_keys[pos] = tmp;
               pos = pos / 2;
            end
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = mhpq_pkg::STAT_EMPTY;
         end else begin
            shadow_keys[1] = shadow_keys[shadow_count];
            shadow_count--;
            pos = 1;
            // Descend toward the larger child; ties keep the left one.
            while (1) begin
               child = 2 * pos;
               larger = pos;
               if (child <= shadow_count && shadow_keys[larger] < shadow_keys[child])
                  larger = child;
               if (child + 1 <= shadow_count && shadow_keys[larger] < shadow_keys[child + 1])
                  larger = child + 1;
               if (larger == pos)
                  break;
               tmp = shadow_keys[larger];
               shadow_keys[larger] = shadow_keys[pos];
               shadow_keys[pos] = tmp;
               pos = larger;
            end
         end
      end
      r.top_value = (shadow_count != 0) ? shadow_keys[1] : '0;
      r.count = shadow_count[CNT_W-1:0];
      return r;
   endfunction

   // Check each accepted response first, then predict for each accepted request.
   always @(posedge clock) begin
      mhpq_pkg::rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_heap_rsps.size() == 0) begin
               $error("unexpected response: status %0d top_value %0d count %0d",
                      rsp_payload.status, rsp_payload.top_value, rsp_payload.count);
               mismatch_count++;
            end else begin
               exp_rsp = pending_heap_rsps.pop_front();
               if (rsp_payload.status !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d",
                         exp_rsp.status, rsp_payload.status);
                  mismatch_count++;
               end
               if (rsp_payload.top_value !== exp_rsp.top_value) begin
                  $error("top_value: expected %0d, actual %0d",
                         exp_rsp.top_value, rsp_payload.top_value);
                  mismatch_count++;
               end
               if (rsp_payload.count !== exp_rsp.count) begin
                  $error("count: expected %0d, actual %0d",
                         exp_rsp.count, rsp_payload.count);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_heap_rsps.push_back(next_heap_response(req_payload));
      end
   end

   // Response side: random stalls, or a long hold when one is requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles_left > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles_left--;
      end else begin
         rsp_stall <= rsp_gaps_on && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Watchdog on total run length.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // Random key: full range, a narrow band with many repeats, or an extreme.
   function automatic logic signed [KEY_W-1:0] random_key();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5)
         return $urandom;
      else if (pick < 9)
         return int'($urandom_range(16)) - 8;
      else
         return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
   endfunction

   // Offer one request from a falling edge and hold it until it is accepted.
   task automatic send_request(input logic func, input logic signed [KEY_W-1:0] value);
      while (req_gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_payload.func  <= func;
      req_payload.value <= value;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   // Extremes of the key, equal keys, empty removes and an ignored remove value.
   task automatic test_directed_cases();
      send_request(mhpq_pkg::FUNC_REMOVE, 32'sh0000_0000);
      send_request(mhpq_pkg::FUNC_INSERT, 32'sh7FFF_FFFF);
      send_request(mhpq_pkg::FUNC_INSERT, 32'sh8000_0000);
      send_request(mhpq_pkg::FUNC_INSERT, 32'sh0000_0000);
      send_request(mhpq_pkg::FUNC_INSERT, -32'sd1);
      send_request(mhpq_pkg::FUNC_INSERT, 32'sd1);
      send_request(mhpq_pkg::FUNC_INSERT, 32'sd5);
      send_request(mhpq_pkg::FUNC_INSERT, 32'sd5);
      send_request(mhpq_pkg::FUNC_REMOVE, 32'shDEAD_BEEF);
      repeat (6) send_request(mhpq_pkg::FUNC_REMOVE, 32'sh5555_5555);
      send_request(mhpq_pkg::FUNC_REMOVE, 32'shFFFF_FFFF);
      send_request(mhpq_pkg::FUNC_REMOVE, 32'shAAAA_AAAA);
   endtask

   // Fill past capacity, then drain past empty, with three key orders.
   task automatic test_fill_and_drain();
      for (int order = 0; order < 3; order++) begin
         for (int i = 0; i < CAPACITY + 3; i++) begin
            case (order)
               0: begin
                  send_request(mhpq_pkg::FUNC_INSERT, i - 30);
               end
               1: begin
                  send_request(mhpq_pkg::FUNC_INSERT, 100 - i);
               end
               default: begin
                  send_request(mhpq_pkg::FUNC_INSERT, random_key());
               end
            endcase
         end
         repeat (CAPACITY + 3) send_request(mhpq_pkg::FUNC_REMOVE, $urandom);
      end
   endtask

   // Mixed traffic whose insert share moves so the count wanders over its range.
   task automatic test_random_mix(input int num_items);
      int insert_pct;
      insert_pct = 50;
      for (int i = 0; i < num_items; i++) begin
         if (i % 50 == 0)
            insert_pct = 25 * $urandom_range(1, 3);
         if ($urandom_range(99) < insert_pct)
            send_request(mhpq_pkg::FUNC_INSERT, random_key());
         else
            send_request(mhpq_pkg::FUNC_REMOVE, $urandom);
      end
   endtask

   // Back-to-back requests with no gaps or stalls on either side.
   task automatic test_back_to_back(input int num_items);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      for (int i = 0; i < num_items; i++) begin
         if ($urandom_range(99) < 60)
            send_request(mhpq_pkg::FUNC_INSERT, random_key());
         else
            send_request(mhpq_pkg::FUNC_REMOVE, $urandom);
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // Hold the response side while requests keep coming so the input backs up.
   task automatic test_output_backpressure(input int num_items);
      hold_cycles_left = 300;
      for (int i = 0; i < num_items; i++) begin
         if (i % 3 == 2)
            send_request(mhpq_pkg::FUNC_REMOVE, $urandom);
         else
            send_request(mhpq_pkg::FUNC_INSERT, random_key());
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      rsp_stall        = 1'b0;
      shadow_count     = 0;
      mismatch_count   = 0;
      hold_cycles_left = 0;
      req_gaps_on      = 1'b1;
      rsp_gaps_on      = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_fill_and_drain();
      test_random_mix(650);
      test_back_to_back(150);
      test_output_backpressure(30);
      req_valid <= 1'b0;

      // Drain outstanding responses, then keep watching for stray responses.
      while (pending_heap_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
